FILE: hdl/chained_hash_table_unit_assert.svh
// Assertion macros for the chained hash table unit.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef CHAINED_HASH_TABLE_UNIT_ASSERT_SVH
`define CHAINED_HASH_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CHU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define CHU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/chu_pkg.sv
// Package for the chained hash table unit: request/response types, codes,
// state enums and default sizes. No dependencies.
package chu_pkg;
    localparam int DEF_BUCKETS      = 16;
    localparam int DEF_BUCKET_DEPTH = 8;
    localparam int KEY_W            = 31;
    localparam int TS_W             = 5;
    localparam int BKT_MAX_W        = 10;
    localparam int DIGIT_W          = 4;
    localparam int DIV_STEPS        = 8;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_DELETED   = 3'd1;
    localparam logic [2:0] ST_DEL_FAIL  = 3'd2;
    localparam logic [2:0] ST_FOUND     = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;

    typedef struct packed {
        logic [1:0]       op;
        logic [KEY_W-1:0] key;
    } t_req;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] bucket;
        logic [2:0] position;
    } t_resp;

    typedef struct packed {
        logic [1:0]           op;
        logic [KEY_W-1:0]     key;
        logic [BKT_MAX_W-1:0] bucket;
    } t_work;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

    typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} t_front_state;

    typedef enum logic [2:0] {
        B_IDLE, B_DISPATCH, B_SCAN_RD, B_SCAN_CMP, B_DEL_RD, B_DEL_WR, B_INS_RD, B_INS_WR
    } t_back_state;
endpackage

FILE: hdl/chu_ram.sv
// Generic simple dual-port RAM with registered read.
// No dependencies.
module chu_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 128
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hdl/chu_front.sv
// Front part: accepts requests and computes the bucket as key modulo the
// table size, four quotient bits per cycle. Depends on chu_pkg.
module chu_front #(
    parameter int BUCKETS = chu_pkg::DEF_BUCKETS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    input  chu_pkg::t_req             i_req,
    input  logic [chu_pkg::TS_W-1:0]  i_table_size,
    input  chu_pkg::t_queue_stat      i_qstat,
    output logic                      busy,
    output logic                      o_push,
    output chu_pkg::t_work            o_work
);
    import chu_pkg::*;

    t_front_state          r_state, n_state;
    logic [1:0]            r_op;
    logic [KEY_W-1:0]      r_key;
    logic [KEY_W:0]        r_shift, n_shift;
    logic [TS_W-1:0]       r_div;
    logic [TS_W-1:0]       r_rem, n_rem;
    logic [2:0]            r_cnt;
    logic [TS_W-1:0]       eff_size;
    logic [TS_W:0]         trial;
    logic [TS_W-1:0]       rem_v;

    // Zero reads as one; anything past the bucket count saturates.
    always_comb begin
        if (i_table_size == '0) begin
            eff_size = TS_W'(1);
        end else if (32'(i_table_size) > BUCKETS) begin
            eff_size = TS_W'(BUCKETS);
        end else begin
            eff_size = i_table_size;
        end
    end

    always_comb begin
        rem_v = r_rem;
        trial = '0;
        for (int k = 0; k < DIGIT_W; k++) begin
            trial = {rem_v, r_shift[KEY_W - k]};
            if (trial >= {1'b0, r_div}) begin
                trial = trial - {1'b0, r_div};
            end
            rem_v = trial[TS_W-1:0];
        end
        n_rem   = rem_v;
        n_shift = {r_shift[KEY_W-DIGIT_W:0], {DIGIT_W{1'b0}}};
    end

    always_comb begin
        n_state = r_state;
        o_push  = 1'b0;
        case (r_state)
            F_IDLE: begin
                if (start) begin
                    n_state = F_DIV;
                end
            end
            F_DIV: begin
                if (r_cnt == 3'(DIV_STEPS - 1)) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_qstat.full) begin
                    o_push  = 1'b1;
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && start) begin
            r_op    <= i_req.op;
            r_key   <= i_req.key;
            r_shift <= {1'b0, i_req.key};
            r_div   <= eff_size;
            r_rem   <= '0;
            r_cnt   <= '0;
        end else if (r_state == F_DIV) begin
            r_shift <= n_shift;
            r_rem   <= n_rem;
            r_cnt   <= r_cnt + 3'd1;
        end
    end

    assign busy          = (r_state != F_IDLE);
    assign o_work.op     = r_op;
    assign o_work.key    = r_key;
    assign o_work.bucket = BKT_MAX_W'(r_rem);
endmodule

FILE: hdl/chu_queue.sv
// Two-entry queue of classified requests between front and back.
// Depends on chu_pkg.
module chu_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  chu_pkg::t_work       i_work,
    input  logic                 i_pop,
    output chu_pkg::t_work       o_work,
    output chu_pkg::t_queue_stat o_stat
);
    import chu_pkg::*;

    t_work      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_work;
        end
    end

    assign o_work       = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);
endmodule

FILE: hdl/chu_back.sv
// Back part: executes insert, delete and search on the bucket store and
// the per-bucket counts. Depends on chu_pkg and chu_ram.
module chu_back #(
    parameter int BUCKETS      = chu_pkg::DEF_BUCKETS,
    parameter int BUCKET_DEPTH = chu_pkg::DEF_BUCKET_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  chu_pkg::t_work       i_work,
    input  chu_pkg::t_queue_stat i_qstat,
    output logic                 o_pop,
    output logic                 o_idle,
    output logic                 o_res_strobe,
    output chu_pkg::t_resp       o_resp
);
    import chu_pkg::*;

    localparam int ENTRIES = BUCKETS * BUCKET_DEPTH;
    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int CW = $clog2(BUCKET_DEPTH + 1);

    t_back_state      r_state, n_state;
    logic [1:0]       r_op;
    logic [KEY_W-1:0] r_key;
    logic [BW-1:0]    r_bucket;
    logic [AW-1:0]    r_base;
    logic [CW-1:0]    r_n, r_idx, n_idx, r_hit, n_hit;
    logic [CW-1:0]    r_counts [BUCKETS];
    logic             cnt_we;
    logic [CW-1:0]    cnt_val;
    logic             we;
    logic [AW-1:0]    waddr, raddr;
    logic [KEY_W-1:0] wdata, rdata;
    logic             r_strobe, n_strobe;
    t_resp            r_resp, n_resp;
    logic [BW-1:0]    head_bucket;

    chu_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign head_bucket = BW'(i_work.bucket);

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_hit    = r_hit;
        o_pop    = 1'b0;
        we       = 1'b0;
        waddr    = r_base + AW'(r_idx);
        wdata    = rdata;
        raddr    = r_base + AW'(r_idx);
        cnt_we   = 1'b0;
        cnt_val  = r_n;
        n_strobe = 1'b0;
        n_resp.status   = ST_NOT_FOUND;
        n_resp.bucket   = 4'(r_bucket);
        n_resp.position = 3'd0;
        case (r_state)
            B_IDLE: begin
                if (!i_qstat.empty) begin
                    o_pop   = 1'b1;
                    n_state = B_DISPATCH;
                end
            end
            B_DISPATCH: begin
                n_idx = '0;
                case (r_op)
                    OP_INSERT: begin
                        if (r_n >= CW'(BUCKET_DEPTH)) begin
                            n_resp.status = ST_FULL;
                            n_strobe      = 1'b1;
                            n_state       = B_IDLE;
                        end else begin
                            n_idx   = r_n;
                            n_state = B_INS_RD;
                        end
                    end
                    OP_DELETE, OP_SEARCH: begin
                        if (r_n == '0) begin
                            n_resp.status = (r_op == OP_DELETE) ? ST_DEL_FAIL : ST_NOT_FOUND;
                            n_strobe      = 1'b1;
                            n_state       = B_IDLE;
                        end else begin
                            n_state = B_SCAN_RD;
                        end
                    end
                    default: begin
                        n_strobe = 1'b1;
                        n_state  = B_IDLE;
                    end
                endcase
            end
            B_INS_RD: begin
                if (r_idx == '0) begin
                    we            = 1'b1;
                    waddr         = r_base;
                    wdata         = r_key;
                    cnt_we        = 1'b1;
                    cnt_val       = r_n + CW'(1);
                    n_resp.status = ST_INSERTED;
                    n_strobe      = 1'b1;
                    n_state       = B_IDLE;
                end else begin
                    raddr   = r_base + AW'(r_idx - CW'(1));
                    n_state = B_INS_WR;
                end
            end
            B_INS_WR: begin
                we      = 1'b1;
                n_idx   = r_idx - CW'(1);
                n_state = B_INS_RD;
            end
            B_SCAN_RD: begin
                n_state = B_SCAN_CMP;
            end
            B_SCAN_CMP: begin
                if (rdata == r_key) begin
                    n_hit = r_idx;
                    if (r_op == OP_SEARCH) begin
                        n_resp.status   = ST_FOUND;
                        n_resp.position = 3'(r_idx);
                        n_strobe        = 1'b1;
                        n_state         = B_IDLE;
                    end else if ((r_idx + CW'(1)) < r_n) begin
                        n_state = B_DEL_RD;
                    end else begin
                        cnt_we          = 1'b1;
                        cnt_val         = r_n - CW'(1);
                        n_resp.status   = ST_DELETED;
                        n_resp.position = 3'(r_idx);
                        n_strobe        = 1'b1;
                        n_state         = B_IDLE;
                    end
                end else if ((r_idx + CW'(1)) == r_n) begin
                    n_resp.status = (r_op == OP_DELETE) ? ST_DEL_FAIL : ST_NOT_FOUND;
                    n_strobe      = 1'b1;
                    n_state       = B_IDLE;
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_state = B_SCAN_RD;
                end
            end
            B_DEL_RD: begin
                raddr   = r_base + AW'(r_idx + CW'(1));
                n_state = B_DEL_WR;
            end
            B_DEL_WR: begin
                we = 1'b1;
                if (((CW+1)'(r_idx) + (CW+1)'(2)) < (CW+1)'(r_n)) begin
                    n_idx   = r_idx + CW'(1);
                    n_state = B_DEL_RD;
                end else begin
                    cnt_we          = 1'b1;
                    cnt_val         = r_n - CW'(1);
                    n_resp.status   = ST_DELETED;
                    n_resp.position = 3'(r_hit);
                    n_strobe        = 1'b1;
                    n_state         = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_strobe <= 1'b0;
            for (int b = 0; b < BUCKETS; b++) begin
                r_counts[b] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            if (cnt_we) begin
                r_counts[r_bucket] <= cnt_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_hit  <= n_hit;
        r_resp <= n_resp;
        if (o_pop) begin
            r_op     <= i_work.op;
            r_key    <= i_work.key;
            r_bucket <= head_bucket;
            r_base   <= AW'(32'(head_bucket) * BUCKET_DEPTH);
            r_n      <= r_counts[head_bucket];
        end
    end

    assign o_idle       = (r_state == B_IDLE);
    assign o_res_strobe = r_strobe;
    assign o_resp       = r_resp;
endmodule

FILE: hdl/chained_hash_table_unit.sv
// Top level of the chained hash table unit: table size register, front,
// queue and back. Depends on chu_pkg, chu_front, chu_queue, chu_back.
//
//  Channel   Handshake                    Payload
//  request   start / busy                 i_req  (op, key)
//  result    o_res_strobe (one cycle)     o_resp (status, bucket, position)
//  config    i_cfg_valid / o_cfg_ready    i_cfg_data (table_size)
//
// The front computes the modulo in F_DIV (four quotient bits per cycle),
// then hands the request to the queue in F_PUSH; busy stays high through
// both states, and longer while the queue is full.
// The back runs one request at a time against the single-port-read store:
// inserts shift entries up and write the key at slot zero; searches and
// deletes compare in turn and deletes close the gap, then the result strobe.
// Reset is synchronous and clears all counts at once; the store needs none.
// The receiver cannot stall; results are strobed for exactly one cycle.
module chained_hash_table_unit #(
    parameter int BUCKETS      = chu_pkg::DEF_BUCKETS,
    parameter int BUCKET_DEPTH = chu_pkg::DEF_BUCKET_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  chu_pkg::t_req            i_req,
    output logic                     o_res_strobe,
    output chu_pkg::t_resp           o_resp,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [chu_pkg::TS_W-1:0] i_cfg_data
);
    import chu_pkg::*;
    `include "chained_hash_table_unit_assert.svh"

    // Table size register, written only while the unit is idle.
    logic [TS_W-1:0] r_table_size;
    logic            push, pop, back_idle;
    t_work           front_work, head_work;
    t_queue_stat     qstat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= TS_W'(16);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_table_size <= i_cfg_data;
        end
    end

    // The config request is taken only with nothing in flight, and never
    // in the same cycle as a new request.
    assign o_cfg_ready = !busy && !start && qstat.empty && back_idle;

    chu_front #(.BUCKETS(BUCKETS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_req        (i_req),
        .i_table_size (r_table_size),
        .i_qstat      (qstat),
        .busy         (busy),
        .o_push       (push),
        .o_work       (front_work)
    );

    chu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_work  (front_work),
        .i_pop   (pop),
        .o_work  (head_work),
        .o_stat  (qstat)
    );

    chu_back #(.BUCKETS(BUCKETS), .BUCKET_DEPTH(BUCKET_DEPTH)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work       (head_work),
        .i_qstat      (qstat),
        .o_pop        (pop),
        .o_idle       (back_idle),
        .o_res_strobe (o_res_strobe),
        .o_resp       (o_resp)
    );

    // A taken request always makes the front busy on the next cycle.
    `CHU_ASSERT_NEXT(a_start_busy, start && !busy, busy)
    // The back needs a dispatch cycle, so strobes never come back to back.
    `CHU_ASSERT_NEXT(a_strobe_gap, o_res_strobe, !o_res_strobe)
    // The front never pushes into a full queue.
    `CHU_ASSERT_NOW(a_no_overflow, push, !qstat.full)
    // An insert or a miss reports position zero.
    `CHU_ASSERT_NOW(a_pos_zero, o_res_strobe && (o_resp.status == ST_INSERTED ||
        o_resp.status == ST_NOT_FOUND || o_resp.status == ST_FULL), o_resp.position == 3'd0)
endmodule

FILE: bench/chained_hash_table_unit_tb.sv
// Self-checking testbench for the chained hash table unit: directed and random
// insert/delete/search requests against a behavioral table. Depends on chu_pkg.
`timescale 1ns / 1ps

module chained_hash_table_unit_tb;
    import chu_pkg::*;

    localparam int BUCKETS = DEF_BUCKETS;
    localparam int DEPTH   = DEF_BUCKET_DEPTH;

    // Behavioral hash table plus the queue of responses it predicts.
    class hash_table_scoreboard;
        logic [KEY_W-1:0] slots [BUCKETS][DEPTH];
        int               fill [BUCKETS];
        logic [TS_W-1:0]  size_reg;
        t_resp            pending [$];
        int               errors;

        function void clear();
            foreach (fill[b]) fill[b] = 0;
            size_reg = TS_W'(16);
            pending.delete();
            errors = 0;
        endfunction

        function void set_size(logic [TS_W-1:0] v);
            size_reg = v;
        endfunction

        // Notes an accepted request and queues the response it must produce.
        function void note_request(t_req r);
            int    modulus;
            int    b;
            int    hit;
            t_resp rsp;
            modulus = (size_reg == 0) ? 1 : (size_reg > BUCKETS) ? BUCKETS : size_reg;
            b = int'(r.key % modulus);
            hit = -1;
            for (int i = 0; i < fill[b]; i++)
                if (hit < 0 && slots[b][i] == r.key) hit = i;
            rsp.status = ST_NOT_FOUND;
            rsp.bucket = 4'(b);
            rsp.position = 3'd0;
            if (r.op == OP_INSERT) begin
                if (fill[b] >= DEPTH) begin
                    rsp.status = ST_FULL;
                end else begin
                    for (int i = fill[b]; i > 0; i--) slots[b][i] = slots[b][i-1];
                    slots[b][0] = r.key;
                    fill[b]++;
                    rsp.status = ST_INSERTED;
                end
            end else if (r.op == OP_DELETE) begin
                if (hit < 0) begin
                    rsp.status = ST_DEL_FAIL;
                end else begin
                    for (int i = hit; i + 1 < fill[b]; i++) slots[b][i] = slots[b][i+1];
                    fill[b]--;
                    rsp.status = ST_DELETED;
                    rsp.position = 3'(hit);
                end
            end else if (r.op == OP_SEARCH) begin
                if (hit >= 0) begin
                    rsp.status = ST_FOUND;
                    rsp.position = 3'(hit);
                end
            end
            pending.push_back(rsp);
        endfunction

        function void check_response(t_resp got);
            t_resp want;
            if (pending.size() == 0) begin
                $error("unexpected response %h", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
            if (got.bucket !== want.bucket) begin
                $error("bucket: expected %0d, actual %0d", want.bucket, got.bucket);
                errors++;
            end
            if (got.position !== want.position) begin
                $error("position: expected %0d, actual %0d", want.position, got.position);
                errors++;
            end
        endfunction
    endclass

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            start = 1'b0;
    logic            busy;
    t_req            i_req = '0;
    logic            o_res_strobe;
    t_resp           o_resp;
    logic            i_cfg_valid = 1'b0;
    logic            o_cfg_ready;
    logic [TS_W-1:0] i_cfg_data = '0;

    hash_table_scoreboard table_model;
    logic [KEY_W-1:0]     recent_keys [$];

    chained_hash_table_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_req(i_req),
        .o_res_strobe(o_res_strobe), .o_resp(o_resp), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Results cannot be held off, so every strobe is checked at its edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_strobe) table_model.check_response(o_resp);
    end

    // Sends one request after a random gap and waits until it is taken.
    // The front stays busy after each taken request, so the
    // leading edge costs no throughput and keeps start from being driven
    // twice in one time step.
    task automatic send_request(logic [1:0] op, logic [KEY_W-1:0] key);
        int   gap;
        t_req r;
        gap = $urandom_range(0, 5);
        @(posedge i_clk);
        repeat (gap) @(posedge i_clk);
        r.op = op;
        r.key = key;
        i_req <= r;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        table_model.note_request(r);
        start <= 1'b0;
        if (recent_keys.size() > 24) void'(recent_keys.pop_front());
        recent_keys.push_back(key);
    endtask

    // Waits for every predicted response plus the worst-case back-end time.
    task automatic drain();
        while (table_model.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_size(logic [TS_W-1:0] v);
        i_cfg_data <= v;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        table_model.set_size(v);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly recent keys or small ones, so buckets fill and hits occur.
    function automatic logic [KEY_W-1:0] pick_key();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4 && recent_keys.size() > 0)
            return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
        if (sel < 8) return KEY_W'($urandom_range(0, 63));
        return KEY_W'($urandom);
    endfunction

    task automatic random_phase(int count);
        int sel;
        logic [1:0] op;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            op = (sel < 45) ? OP_INSERT : (sel < 70) ? OP_DELETE : (sel < 97) ? OP_SEARCH : 2'd3;
            send_request(op, pick_key());
        end
    endtask

    initial begin
        logic [TS_W-1:0] sizes [6];
        table_model = new();
        table_model.clear();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes of the key, every op, a full bucket, the unused op.
        send_request(OP_SEARCH, '0);
        send_request(OP_DELETE, '0);
        send_request(OP_INSERT, '1);
        send_request(OP_INSERT, '0);
        for (int i = 0; i < 9; i++) send_request(OP_INSERT, KEY_W'(16 * i + 3));
        send_request(OP_SEARCH, KEY_W'(3));
        send_request(OP_SEARCH, KEY_W'(16 * 7 + 3));
        send_request(OP_DELETE, KEY_W'(16 * 4 + 3));
        send_request(OP_SEARCH, '1);
        send_request(2'd3, '1);
        send_request(OP_INSERT, KEY_W'(31'h5555_5555));
        send_request(OP_INSERT, KEY_W'(31'h2AAA_AAAA));
        send_request(OP_DELETE, '1);
        // The sender holds off here until every response is back.
        drain();

        // Sizes include zero, one, the top and values above the bucket count.
        sizes = '{5'd0, 5'd1, 5'd31, 5'd7, 5'd17, 5'd16};
        foreach (sizes[s]) begin
            write_size(sizes[s]);
            random_phase(220);
            drain();
        end

        if (table_model.errors == 0 && table_model.pending.size() == 0)
            $display("chained_hash_table_unit_tb passed");
        else
            $display("chained_hash_table_unit_tb failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("chained_hash_table_unit_tb failed");
        $finish;
    end
endmodule

FILE: files.f
+incdir+hdl
hdl/chu_pkg.sv
hdl/chu_ram.sv
hdl/chu_front.sv
hdl/chu_queue.sv
hdl/chu_back.sv
hdl/chained_hash_table_unit.sv
bench/chained_hash_table_unit_tb.sv
